### design/pcfe_pkg.sv
// package: shared types, codes and constants of the pump command frame encoder
`timescale 1ns / 1ps
package pcfe_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegPumpAddress  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSequenceByte = 1'b1;
  localparam logic [7:0] PumpAddressReset  = 8'd49;
  localparam logic [7:0] SequenceByteReset = 8'd49;

  localparam logic [7:0] FrameStx  = 8'h02;
  localparam logic [7:0] FrameEtx  = 8'h03;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [7:0] ChrZ      = 8'h5A;
  localparam logic [7:0] ChrN      = 8'h4E;
  localparam logic [7:0] ChrR      = 8'h52;
  localparam logic [7:0] ChrO      = 8'h4F;
  localparam logic [7:0] ChrI      = 8'h49;
  localparam logic [7:0] ChrP      = 8'h50;
  localparam logic [7:0] ChrD      = 8'h44;
  localparam logic [7:0] ChrA      = 8'h41;
  localparam logic [7:0] ChrL      = 8'h4C;
  localparam logic [7:0] ChrLowV   = 8'h76;
  localparam logic [7:0] ChrV      = 8'h56;
  localparam logic [7:0] ChrS      = 8'h53;
  localparam logic [7:0] ChrLowC   = 8'h63;
  localparam logic [7:0] ChrQ      = 8'h51;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_PORT   = 3'd1,
    ACT_REL    = 3'd2,
    ACT_ABS    = 3'd3,
    ACT_MOTOR  = 3'd4,
    ACT_STATUS = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_EMIT
  } front_state_e;

  typedef enum logic [2:0] {
    B_STX,
    B_ADDR,
    B_SEQ,
    B_BODY,
    B_R,
    B_ETX,
    B_SUM
  } back_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_entry_t;

endpackage

### design/pcfe_cmd_if.sv
// interface: command request channel
`timescale 1ns / 1ps
interface pcfe_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        resolution_mode;
  logic [3:0]  port_number;
  logic        port_direction;
  logic        syringe_direction;
  logic [16:0] step_amount;
  logic [6:0]  accel_code;
  logic [13:0] start_speed;
  logic [16:0] top_speed;
  logic [6:0]  speed_select;
  logic [13:0] stop_speed;

  modport source (
    output valid, action, resolution_mode, port_number, port_direction,
    output syringe_direction, step_amount, accel_code, start_speed, top_speed,
    output speed_select, stop_speed,
    input  ready
  );
  modport sink (
    input  valid, action, resolution_mode, port_number, port_direction,
    input  syringe_direction, step_amount, accel_code, start_speed, top_speed,
    input  speed_select, stop_speed,
    output ready
  );
endinterface

### design/pcfe_frame_if.sv
// interface: frame byte output channel
`timescale 1ns / 1ps
interface pcfe_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

### design/pcfe_cfg_if.sv
// interface: configuration register write channel
`timescale 1ns / 1ps
interface pcfe_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pcfe_pkg::CfgIdxW-1:0] index;
  logic [7:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/pcfe_front.sv
// front end: accepts commands, converts numbers to digits, queues the command body
`timescale 1ns / 1ps
module pcfe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pcfe_cmd_if.sink              cmd_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output pcfe_pkg::body_entry_t push_entry_o
);

  localparam int unsigned NumLanes  = 5;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned StepW     = $clog2(NumDigits);
  localparam logic [17:0] Recip10   = 18'd209716;
  localparam int unsigned RecipShift = 21;

  // quotient and remainder by ten, exact for 17-bit values
  function automatic logic [20:0] div10(input logic [16:0] v);
    logic [34:0] prod;
    logic [16:0] q;
    logic [16:0] r;
    prod = 35'(v) * 35'(Recip10);
    q    = 17'(prod >> RecipShift);
    r    = v - 17'(q * 17'd10);
    return {q, r[3:0]};
  endfunction

  function automatic logic [7:0] dig_chr(input logic [3:0] d);
    return pcfe_pkg::DigitBase | {4'h0, d};
  endfunction

  pcfe_pkg::front_state_e state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [4:0]       idx_q;
  logic [2:0]       act_q;
  logic             mode_q;
  logic [3:0]       port_q;
  logic             pdir_q;
  logic             sdir_q;
  logic [16:0]      val_q [NumLanes];
  logic [3:0]       dig_q [NumLanes][NumDigits];
  logic [20:0]      div_res [NumLanes];

  logic             accept;
  logic             act_ok;
  logic             needs_digits;
  logic [7:0]       body_byte;
  logic [4:0]       last_idx;
  logic [StepW-1:0] pos;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      div_res[l] = div10(val_q[l]);
    end
  end

  assign act_ok = cmd_i.action <= 3'(pcfe_pkg::ACT_STATUS);
  assign needs_digits = (cmd_i.action == 3'(pcfe_pkg::ACT_REL)) ||
                        (cmd_i.action == 3'(pcfe_pkg::ACT_ABS)) ||
                        (cmd_i.action == 3'(pcfe_pkg::ACT_MOTOR));
  assign accept = cmd_i.valid && cmd_i.ready;

  // body byte at the current index
  always_comb begin
    body_byte = '0;
    last_idx  = '0;
    pos       = '0;
    case (pcfe_pkg::action_e'(act_q))
      pcfe_pkg::ACT_INIT: begin
        last_idx = 5'd2;
        case (idx_q)
          5'd0:    body_byte = pcfe_pkg::ChrZ;
          5'd1:    body_byte = pcfe_pkg::ChrN;
          default: body_byte = pcfe_pkg::DigitBase | {7'h00, mode_q};
        endcase
      end
      pcfe_pkg::ACT_PORT: begin
        last_idx = 5'd1;
        case (idx_q)
          5'd0:    body_byte = pdir_q ? pcfe_pkg::ChrI : pcfe_pkg::ChrO;
          default: body_byte = pcfe_pkg::DigitBase + {4'h0, port_q};
        endcase
      end
      pcfe_pkg::ACT_REL, pcfe_pkg::ACT_ABS: begin
        last_idx = 5'd5;
        case (idx_q)
          5'd0: begin
            if (act_q == 3'(pcfe_pkg::ACT_ABS)) begin
              body_byte = pcfe_pkg::ChrA;
            end else begin
              body_byte = sdir_q ? pcfe_pkg::ChrD : pcfe_pkg::ChrP;
            end
          end
          default: begin
            pos       = StepW'(5'd5 - idx_q);
            body_byte = dig_chr(dig_q[2][pos]);
          end
        endcase
      end
      pcfe_pkg::ACT_MOTOR: begin
        last_idx = 5'd21;
        case (idx_q)
          5'd0:  body_byte = pcfe_pkg::ChrL;
          5'd1, 5'd2: begin
            pos       = StepW'(5'd2 - idx_q);
            body_byte = dig_chr(dig_q[0][pos]);
          end
          5'd3:  body_byte = pcfe_pkg::ChrLowV;
          5'd4, 5'd5, 5'd6, 5'd7: begin
            pos       = StepW'(5'd7 - idx_q);
            body_byte = dig_chr(dig_q[1][pos]);
          end
          5'd8:  body_byte = pcfe_pkg::ChrV;
          5'd9, 5'd10, 5'd11, 5'd12, 5'd13: begin
            pos       = StepW'(5'd13 - idx_q);
            body_byte = dig_chr(dig_q[2][pos]);
          end
          5'd14: body_byte = pcfe_pkg::ChrS;
          5'd15, 5'd16: begin
            pos       = StepW'(5'd16 - idx_q);
            body_byte = dig_chr(dig_q[3][pos]);
          end
          5'd17: body_byte = pcfe_pkg::ChrLowC;
          default: begin
            pos       = StepW'(5'd21 - idx_q);
            body_byte = dig_chr(dig_q[4][pos]);
          end
        endcase
      end
      pcfe_pkg::ACT_STATUS: begin
        last_idx  = 5'd0;
        body_byte = pcfe_pkg::ChrQ;
      end
      default: begin
        last_idx  = '0;
        body_byte = '0;
      end
    endcase
  end

  assign push_entry_o.data = body_byte;
  assign push_entry_o.last = (idx_q == last_idx);

  always_comb begin
    state_d      = state_q;
    cmd_i.ready  = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      pcfe_pkg::F_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid && act_ok) begin
          state_d = needs_digits ? pcfe_pkg::F_CONV : pcfe_pkg::F_EMIT;
        end
      end
      pcfe_pkg::F_CONV: begin
        if (step_q == StepW'(NumDigits - 1)) begin
          state_d = pcfe_pkg::F_EMIT;
        end
      end
      pcfe_pkg::F_EMIT: begin
        push_valid_o = 1'b1;
        if (push_ready_i && push_entry_o.last) begin
          state_d = pcfe_pkg::F_IDLE;
        end
      end
      default: state_d = pcfe_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcfe_pkg::F_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q <= '0;
        idx_q  <= '0;
      end else if (state_q == pcfe_pkg::F_CONV) begin
        step_q <= step_q + 1'b1;
      end else if (push_valid_o && push_ready_i) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= cmd_i.action;
      mode_q   <= cmd_i.resolution_mode;
      port_q   <= cmd_i.port_number;
      pdir_q   <= cmd_i.port_direction;
      sdir_q   <= cmd_i.syringe_direction;
      val_q[0] <= 17'(cmd_i.accel_code);
      val_q[1] <= 17'(cmd_i.start_speed);
      val_q[2] <= (cmd_i.action == 3'(pcfe_pkg::ACT_MOTOR)) ? cmd_i.top_speed
                                                             : cmd_i.step_amount;
      val_q[3] <= 17'(cmd_i.speed_select);
      val_q[4] <= 17'(cmd_i.stop_speed);
    end else if (state_q == pcfe_pkg::F_CONV) begin
      for (int l = 0; l < NumLanes; l++) begin
        val_q[l]         <= div_res[l][20:4];
        dig_q[l][step_q] <= div_res[l][3:0];
      end
    end
  end

endmodule

### design/pcfe_queue.sv
// small queue of command body bytes between front and back
`timescale 1ns / 1ps
module pcfe_queue #(
  parameter int unsigned Depth = pcfe_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  pcfe_pkg::body_entry_t push_entry_i,
  output logic                  pop_valid_o,
  input  logic                  pop_i,
  output pcfe_pkg::body_entry_t pop_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcfe_pkg::body_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### design/pcfe_back.sv
// back end: wraps the body in header and trailer, builds the checksum, drives the output
`timescale 1ns / 1ps
module pcfe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            pump_address_i,
  input  logic [7:0]            sequence_byte_i,
  input  logic                  pop_valid_i,
  input  pcfe_pkg::body_entry_t pop_entry_i,
  output logic                  pop_o,
  pcfe_frame_if.source          frame_o
);

  pcfe_pkg::back_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       end_q, end_d;
  logic [7:0] csum_q, csum_d;
  logic       load;
  logic       emit;

  assign load = !out_valid_q || frame_o.ready;

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    pop_o   = 1'b0;
    byte_d  = byte_q;
    end_d   = 1'b0;
    case (state_q)
      pcfe_pkg::B_STX: begin
        if (pop_valid_i && load) begin
          emit    = 1'b1;
          byte_d  = pcfe_pkg::FrameStx;
          state_d = pcfe_pkg::B_ADDR;
        end
      end
      pcfe_pkg::B_ADDR: begin
        if (load) begin
          emit    = 1'b1;
          byte_d  = pump_address_i;
          state_d = pcfe_pkg::B_SEQ;
        end
      end
      pcfe_pkg::B_SEQ: begin
        if (load) begin
          emit    = 1'b1;
          byte_d  = sequence_byte_i;
          state_d = pcfe_pkg::B_BODY;
        end
      end
      pcfe_pkg::B_BODY: begin
        if (pop_valid_i && load) begin
          emit   = 1'b1;
          pop_o  = 1'b1;
          byte_d = pop_entry_i.data;
          if (pop_entry_i.last) begin
            state_d = pcfe_pkg::B_R;
          end
        end
      end
      pcfe_pkg::B_R: begin
        if (load) begin
          emit    = 1'b1;
          byte_d  = pcfe_pkg::ChrR;
          state_d = pcfe_pkg::B_ETX;
        end
      end
      pcfe_pkg::B_ETX: begin
        if (load) begin
          emit    = 1'b1;
          byte_d  = pcfe_pkg::FrameEtx;
          state_d = pcfe_pkg::B_SUM;
        end
      end
      pcfe_pkg::B_SUM: begin
        if (load) begin
          emit    = 1'b1;
          byte_d  = csum_q;
          end_d   = 1'b1;
          state_d = pcfe_pkg::B_STX;
        end
      end
      default: state_d = pcfe_pkg::B_STX;
    endcase
  end

  assign csum_d = (state_q == pcfe_pkg::B_STX) ? pcfe_pkg::FrameStx : (csum_q ^ byte_d);

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcfe_pkg::B_STX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      end_q  <= end_d;
      csum_q <= csum_d;
    end
  end

  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = byte_q;
  assign frame_o.frame_end  = end_q;

endmodule

### design/pump_command_frame_encoder.sv
// top level: pump command frame encoder
//
//   channel  dir  modport        carries
//   cmd_i    in   pcfe_cmd_if    one command request per transfer
//   cfg_i    in   pcfe_cfg_if    register index and write data
//   frame_o  out  pcfe_frame_if  one frame byte per transfer, frame_end on checksum
//
// a frame holds 7 to 28 bytes; the back end sends one byte per cycle while frame_o is
// ready and the queue holds body data; the front end takes a command, converts the
// numbers to digits on moves and motor commands, then pushes the body into the queue;
// with the default depth of 4 a longer body waits while the back end sends the header
// the next command is taken once the previous body is queued
// reset clears control state only; output stalls back up through the queue to cmd_i
`timescale 1ns / 1ps
module pump_command_frame_encoder #(
  parameter int unsigned QueueDepth = pcfe_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcfe_cmd_if.sink      cmd_i,
  pcfe_cfg_if.sink      cfg_i,
  pcfe_frame_if.source  frame_o
);

  logic [7:0] pump_address_q;
  logic [7:0] sequence_byte_q;

  logic                  push_valid;
  logic                  push_ready;
  pcfe_pkg::body_entry_t push_entry;
  logic                  pop_valid;
  logic                  pop;
  pcfe_pkg::body_entry_t pop_entry;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_address_q  <= pcfe_pkg::PumpAddressReset;
      sequence_byte_q <= pcfe_pkg::SequenceByteReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == pcfe_pkg::RegPumpAddress) begin
        pump_address_q <= cfg_i.data;
      end
      if (cfg_i.index == pcfe_pkg::RegSequenceByte) begin
        sequence_byte_q <= cfg_i.data;
      end
    end
  end

  pcfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  pcfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  pcfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pump_address_i  (pump_address_q),
    .sequence_byte_i (sequence_byte_q),
    .pop_valid_i     (pop_valid),
    .pop_entry_i     (pop_entry),
    .pop_o           (pop),
    .frame_o         (frame_o)
  );

`ifndef SYNTH
  // a known command keeps the front end busy on the next cycle
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready && (cmd_i.action <= 3'(pcfe_pkg::ACT_STATUS))
    |=> !cmd_i.ready)
    else $error("front end ready right after taking a command");

  // an unknown command is dropped without stalling
  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready && (cmd_i.action > 3'(pcfe_pkg::ACT_STATUS))
    |=> cmd_i.ready)
    else $error("unknown command stalled the front end");

  // the back end only reads the queue when it holds data
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("queue read while empty");
`endif

endmodule
